@@ rtl/mrq_pkg.sv @@
// Package for the multilevel ready queue: action and status codes, link encoding,
// controller states and the structs between the controller and the cell row.
// No dependencies.
`default_nettype none
package mrq_pkg;

    // Width of a process id and of a level field, fixed by the interface.
    localparam int unsigned PID_W = 4;
    localparam int unsigned LVL_W = 2;

    // A link with bit 4 set marks the end of a list.
    localparam logic [PID_W:0] LINK_NONE = 5'h10;

    typedef enum logic [1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_REMOVE  = 2'd2
    } t_action;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_ID    = 3'd1;
    localparam logic [2:0] ST_NOT_READY = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_DUP       = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ENQ_LINK,
        S_POP,
        S_WALK,
        S_UNLINK,
        S_UNLINK_END,
        S_RESP
    } t_state;

    // Lookup addresses presented to every cell of the row.
    typedef struct packed {
        logic [PID_W-1:0] link_addr;
        logic [PID_W-1:0] q_addr;
    } t_cell_rd;

    // One link write and one queued-flag write per cycle.
    typedef struct packed {
        logic             link_we;
        logic [PID_W-1:0] link_addr;
        logic [PID_W:0]   link_data;
        logic             q_we;
        logic [PID_W-1:0] q_addr;
        logic             q_val;
    } t_cell_wr;

    // Data handed from one cell to the next along the row.
    typedef struct packed {
        logic [PID_W:0] link;
        logic           queued;
    } t_chain;

endpackage
`default_nettype wire

@@ rtl/mrq_req_if.sv @@
// Request channel of the multilevel ready queue: valid/ready handshake and one command.
// Depends on mrq_pkg for field widths.
`default_nettype none
interface mrq_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                action;
    logic [mrq_pkg::PID_W-1:0] pid;
    logic [mrq_pkg::LVL_W-1:0] priority_req;
    logic                      is_ready;

    modport source (output valid, action, pid, priority_req, is_ready, input ready);
    modport sink   (input valid, action, pid, priority_req, is_ready, output ready);
endinterface
`default_nettype wire

@@ rtl/mrq_rsp_if.sv @@
// Response channel of the multilevel ready queue: valid/ready handshake and one result.
// Depends on mrq_pkg for field widths.
`default_nettype none
interface mrq_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                status;
    logic [mrq_pkg::PID_W-1:0] out_pid;
    logic [mrq_pkg::LVL_W-1:0] out_priority;

    modport source (output valid, status, out_pid, out_priority, input ready);
    modport sink   (input valid, status, out_pid, out_priority, output ready);
endinterface
`default_nettype wire

@@ rtl/mrq_cell.sv @@
// One process-id cell: holds the id's next link and queued flag, answers lookups
// by replacing the chain data when addressed. Depends on mrq_pkg.
`default_nettype none
module mrq_cell #(
    parameter int unsigned ID = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  mrq_pkg::t_cell_rd      i_rd,
    input  mrq_pkg::t_cell_wr      i_wr,
    input  mrq_pkg::t_chain        i_chain,
    output mrq_pkg::t_chain        o_chain
);
    import mrq_pkg::*;

    localparam logic [PID_W-1:0] MY_ID = PID_W'(ID);

    logic [PID_W:0] r_link;
    logic           r_queued;

    always_ff @(posedge i_clk) begin
        if (i_wr.link_we && (i_wr.link_addr == MY_ID)) begin
            r_link <= i_wr.link_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queued <= 1'b0;
        end else if (i_wr.q_we && (i_wr.q_addr == MY_ID)) begin
            r_queued <= i_wr.q_val;
        end
    end

    always_comb begin
        o_chain.link   = (i_rd.link_addr == MY_ID) ? r_link : i_chain.link;
        o_chain.queued = (i_rd.q_addr == MY_ID) ? r_queued : i_chain.queued;
    end

endmodule
`default_nettype wire

@@ rtl/mrq_cell_row.sv @@
// Row of process-id cells chained end to end; the addressed cell's link and flag
// come out at the far end. Depends on mrq_pkg and mrq_cell.
`default_nettype none
module mrq_cell_row #(
    parameter int unsigned NUM_PIDS = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  mrq_pkg::t_cell_rd      i_rd,
    input  mrq_pkg::t_cell_wr      i_wr,
    output mrq_pkg::t_chain        o_chain
);
    import mrq_pkg::*;

    t_chain chain [NUM_PIDS+1];

    // An id with no cell reads as an end-of-list link and not queued.
    assign chain[0] = '{link: LINK_NONE, queued: 1'b0};

    for (genvar g = 0; g < NUM_PIDS; g++) begin : g_cell
        mrq_cell #(.ID(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_rd    (i_rd),
            .i_wr    (i_wr),
            .i_chain (chain[g]),
            .o_chain (chain[g+1])
        );
    end

    assign o_chain = chain[NUM_PIDS];

endmodule
`default_nettype wire

@@ rtl/multilevel_ready_queue_core.sv @@
// Top level of the multilevel ready queue: controller sequencer, level head/tail
// registers and the process-id cell row. Depends on mrq_pkg, the channel interfaces
// and mrq_cell_row.
//
// This block is a scheduler ready queue with NUM_LEVELS priority levels, level 0 the
// most urgent, each a FIFO of process ids kept as a linked list. The per-id next links
// and queued flags live in a row of cells, one per id; the controller holds each
// level's head, tail and non-empty flag. Commands are enqueue, dequeue of the most
// urgent head, and remove of a named id from a level. Exactly one response follows
// every accepted request, in order. One request is worked on at a time. A remove
// walks down the level's list at one link per cycle through the cell row. A new
// request is accepted in the cycle after the response is handed to the output
// register, while that response still waits to be taken. Level fields beyond
// NUM_LEVELS-1 are clamped to the last level. Reset needs no clearing pass:
// non-empty and queued flags are cleared at once, and links, heads and tails are
// only read once written.
`default_nettype none
module multilevel_ready_queue_core #(
    parameter int unsigned NUM_PIDS   = 10,
    parameter int unsigned NUM_LEVELS = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mrq_req_if.sink    i_req,
    mrq_rsp_if.source  o_rsp
);
    import mrq_pkg::*;

    localparam int unsigned LW = $clog2(NUM_LEVELS);
    localparam int unsigned SW = $clog2(NUM_PIDS + 1);
    localparam logic [PID_W:0] PID_LIMIT = (PID_W + 1)'(NUM_PIDS);
    localparam logic [LVL_W:0] LVL_LIMIT = (LVL_W + 1)'(NUM_LEVELS);
    localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(NUM_LEVELS - 1);

    // Controller state and the captured request.
    t_state           r_state, n_state;
    logic [1:0]       r_act;
    logic [PID_W-1:0] r_pid;
    logic [LVL_W-1:0] r_lvl, n_lvl;
    logic             r_rdy;

    // Walk registers for remove.
    logic [PID_W-1:0] r_cur, n_cur;
    logic [PID_W-1:0] r_prev, n_prev;
    logic [SW-1:0]    r_steps, n_steps;

    // Result waiting to enter the output register.
    logic [2:0]       r_status, n_status;
    logic [PID_W-1:0] r_opid, n_opid;
    logic [LVL_W-1:0] r_olvl, n_olvl;

    // Level bookkeeping.
    logic [PID_W-1:0] r_head [NUM_LEVELS];
    logic [PID_W-1:0] r_tail [NUM_LEVELS];
    logic             head_we, tail_we;
    logic [PID_W-1:0] head_data, tail_data;
    logic [NUM_LEVELS-1:0] r_nonempty, n_nonempty;

    // Output register.
    logic             r_ovalid, n_ovalid;
    logic [2:0]       r_ostatus;
    logic [PID_W-1:0] r_ostatus_pid;
    logic [LVL_W-1:0] r_ostatus_lvl;
    logic             out_load;

    // Cell row.
    t_cell_rd cell_rd;
    t_cell_wr cell_wr;
    t_chain   cell_q;

    logic             in_fire;
    logic [LVL_W-1:0] req_lvl;
    logic [LW-1:0]    lvl_idx;
    logic             pid_ok;
    logic             link_ok;
    logic [PID_W-1:0] link_id;
    logic             deq_found;
    logic [LVL_W-1:0] deq_lvl;

    mrq_cell_row #(.NUM_PIDS(NUM_PIDS)) u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (cell_rd),
        .i_wr    (cell_wr),
        .o_chain (cell_q)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign in_fire     = i_req.valid && i_req.ready;

    // Out-of-range levels go to the last level.
    assign req_lvl = ({1'b0, i_req.priority_req} >= LVL_LIMIT) ? LVL_LAST : i_req.priority_req;

    assign lvl_idx = r_lvl[LW-1:0];
    assign pid_ok  = ({1'b0, r_pid} < PID_LIMIT);
    assign link_id = cell_q.link[PID_W-1:0];
    assign link_ok = !cell_q.link[PID_W] && ({1'b0, link_id} < PID_LIMIT);

    // Most urgent non-empty level.
    always_comb begin
        deq_found = 1'b0;
        deq_lvl   = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (r_nonempty[i]) begin
                deq_found = 1'b1;
                deq_lvl   = LVL_W'(i);
            end
        end
    end

    assign out_load = (r_state == S_RESP) && (!r_ovalid || o_rsp.ready);

    // Next state and datapath control.
    always_comb begin
        n_state    = r_state;
        n_lvl      = r_lvl;
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_steps    = r_steps;
        n_status   = r_status;
        n_opid     = r_opid;
        n_olvl     = r_olvl;
        n_nonempty = r_nonempty;
        head_we    = 1'b0;
        head_data  = r_pid;
        tail_we    = 1'b0;
        tail_data  = r_pid;
        cell_rd    = '{link_addr: r_cur, q_addr: r_pid};
        cell_wr    = '0;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                // Default outcome is a rejection with zeroed id and level.
                n_status = ST_EMPTY;
                n_opid   = '0;
                n_olvl   = '0;
                n_state  = S_RESP;
                case (r_act)
                    ACT_ENQUEUE: begin
                        if (!pid_ok) begin
                            n_status = ST_BAD_ID;
                        end else if (!r_rdy) begin
                            n_status = ST_NOT_READY;
                        end else if (cell_q.queued) begin
                            n_status = ST_DUP;
                        end else begin
                            n_status        = ST_OK;
                            n_opid          = r_pid;
                            n_olvl          = r_lvl;
                            cell_wr.link_we   = 1'b1;
                            cell_wr.link_addr = r_pid;
                            cell_wr.link_data = LINK_NONE;
                            cell_wr.q_we      = 1'b1;
                            cell_wr.q_addr    = r_pid;
                            cell_wr.q_val     = 1'b1;
                            if (!r_nonempty[lvl_idx]) begin
                                head_we             = 1'b1;
                                tail_we             = 1'b1;
                                n_nonempty[lvl_idx] = 1'b1;
                            end else begin
                                n_state = S_ENQ_LINK;
                            end
                        end
                    end
                    ACT_DEQUEUE: begin
                        if (deq_found) begin
                            n_lvl   = deq_lvl;
                            n_state = S_POP;
                        end
                    end
                    ACT_REMOVE: begin
                        if (!pid_ok) begin
                            n_status = ST_BAD_ID;
                        end else if (r_nonempty[lvl_idx]) begin
                            if (r_head[lvl_idx] == r_pid) begin
                                n_state = S_POP;
                            end else begin
                                n_cur   = r_head[lvl_idx];
                                n_steps = '0;
                                n_state = S_WALK;
                            end
                        end
                    end
                    default: begin
                        n_status = ST_EMPTY;
                    end
                endcase
            end

            S_ENQ_LINK: begin
                // Append behind the old tail.
                cell_wr.link_we   = 1'b1;
                cell_wr.link_addr = r_tail[lvl_idx];
                cell_wr.link_data = {1'b0, r_pid};
                tail_we           = 1'b1;
                n_state           = S_RESP;
            end

            S_POP: begin
                cell_rd.link_addr = r_head[lvl_idx];
                if (link_ok) begin
                    head_we   = 1'b1;
                    head_data = link_id;
                end else begin
                    n_nonempty[lvl_idx] = 1'b0;
                end
                cell_wr.link_we   = 1'b1;
                cell_wr.link_addr = r_head[lvl_idx];
                cell_wr.link_data = LINK_NONE;
                cell_wr.q_we      = 1'b1;
                cell_wr.q_addr    = r_head[lvl_idx];
                cell_wr.q_val     = 1'b0;
                n_status = ST_OK;
                n_opid   = r_head[lvl_idx];
                n_olvl   = r_lvl;
                n_state  = S_RESP;
            end

            S_WALK: begin
                if ((r_steps == SW'(NUM_PIDS)) || !link_ok) begin
                    n_state = S_RESP;
                end else if (link_id == r_pid) begin
                    n_prev  = r_cur;
                    n_cur   = link_id;
                    n_state = S_UNLINK;
                end else begin
                    n_cur   = link_id;
                    n_steps = r_steps + SW'(1);
                end
            end

            S_UNLINK: begin
                // Predecessor takes over the removed id's successor.
                cell_wr.link_we   = 1'b1;
                cell_wr.link_addr = r_prev;
                cell_wr.link_data = cell_q.link;
                cell_wr.q_we      = 1'b1;
                cell_wr.q_addr    = r_cur;
                cell_wr.q_val     = 1'b0;
                if (cell_q.link[PID_W]) begin
                    tail_we   = 1'b1;
                    tail_data = r_prev;
                end
                n_state = S_UNLINK_END;
            end

            S_UNLINK_END: begin
                cell_wr.link_we   = 1'b1;
                cell_wr.link_addr = r_cur;
                cell_wr.link_data = LINK_NONE;
                n_status = ST_OK;
                n_opid   = r_cur;
                n_olvl   = r_lvl;
                n_state  = S_RESP;
            end

            S_RESP: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when the sink takes the transaction.
    always_comb begin
        n_ovalid = r_ovalid;
        if (out_load) begin
            n_ovalid = 1'b1;
        end else if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_nonempty <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_nonempty <= n_nonempty;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_act <= i_req.action;
            r_pid <= i_req.pid;
            r_lvl <= req_lvl;
            r_rdy <= i_req.is_ready;
        end else begin
            r_lvl <= n_lvl;
        end
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_steps  <= n_steps;
        r_status <= n_status;
        r_opid   <= n_opid;
        r_olvl   <= n_olvl;
        if (head_we) begin
            r_head[lvl_idx] <= head_data;
        end
        if (tail_we) begin
            r_tail[lvl_idx] <= tail_data;
        end
        if (out_load) begin
            r_ostatus     <= r_status;
            r_ostatus_pid <= r_opid;
            r_ostatus_lvl <= r_olvl;
        end
    end

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.status       = r_ostatus;
    assign o_rsp.out_pid      = r_ostatus_pid;
    assign o_rsp.out_priority = r_ostatus_lvl;

    // A rejected command never reports an id or a level.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != ST_OK)) |->
            ((o_rsp.out_pid == '0) && (o_rsp.out_priority == '0)))
        else $error("rejected response carries a nonzero id or level");

    // A successful response names an id that has a cell.
    a_ok_pid_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == ST_OK)) |-> ({1'b0, o_rsp.out_pid} < PID_LIMIT))
        else $error("successful response names an id out of range");

    // The list walk never runs past its step bound.
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_steps <= SW'(NUM_PIDS)))
        else $error("remove walk exceeded its step bound");

    // An accepted request is decoded in the next cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_EXEC))
        else $error("accepted request was not decoded");

endmodule
`default_nettype wire
